// ----- rtl/fnpa_pkg.sv -----
package fnpa_pkg;

    localparam int NODES_PER_BLOCK = 16;
    localparam int MAX_BLOCKS      = 4;
    localparam int TOTAL_NODES     = NODES_PER_BLOCK * MAX_BLOCKS;

    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int LIM_W    = 3;
    localparam int STATUS_W = 2;
    localparam int GROWN_W  = $clog2(MAX_BLOCKS + 1);

    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [LIM_W-1:0]    t_lim;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [GROWN_W-1:0]  t_grown;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_EXHAUSTED = 2'd1;
    localparam t_status ST_REJECTED  = 2'd2;

    // link of a node that was never written: next node of its block, 0 at block end
    function automatic t_idx implicit_link(t_idx i);
        logic last;
        last = 1'b0;
        for (int b = 0; b < MAX_BLOCKS; b++) begin
            if (int'(i) == b * NODES_PER_BLOCK + NODES_PER_BLOCK - 1) begin
                last = 1'b1;
            end
        end
        return last ? t_idx'(0) : t_idx'(i + t_idx'(1));
    endfunction

    function automatic t_idx block_base(t_grown g);
        return t_idx'(int'(g) * NODES_PER_BLOCK);
    endfunction

    function automatic t_idx block_last(t_grown g);
        return t_idx'(int'(g) * NODES_PER_BLOCK + NODES_PER_BLOCK - 1);
    endfunction

    // one past the highest index grown so far
    function automatic t_cnt grown_end(t_grown g);
        return t_cnt'(int'(g) * NODES_PER_BLOCK);
    endfunction

endpackage

// ----- rtl/fnpa_if.sv -----
interface fnpa_req_if;
    logic                 valid;
    logic                 ready;
    logic                 mode;
    fnpa_pkg::t_idx       node_index;

    modport source (output valid, output mode, output node_index, input ready);
    modport sink   (input valid, input mode, input node_index, output ready);
endinterface

interface fnpa_rsp_if;
    logic                 valid;
    logic                 ready;
    fnpa_pkg::t_status    status;
    fnpa_pkg::t_idx       granted_index;
    fnpa_pkg::t_cnt       free_count;
    fnpa_pkg::t_cnt       used_count;

    modport source (output valid, output status, output granted_index,
                    output free_count, output used_count, input ready);
    modport sink   (input valid, input status, input granted_index,
                    input free_count, input used_count, output ready);
endinterface

// ----- rtl/fixed_node_pool_allocator.sv -----
// An accepted request beat moves from IDLE to EXEC; the next-link memory read is
//   issued at accept, and EXEC does the update and write-back once the response
//   register is free or draining. No new request is taken until then.
// Reset (synchronous, i_rst_n low): block 0 is the free list, counters and
//   block limit take their defaults; link memory content is not cleared, the
//   per-entry written flags are, so no clearing pass is needed.
module fixed_node_pool_allocator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  fnpa_pkg::t_lim       i_cfg_wdata,
    fnpa_req_if.sink             i_req,
    fnpa_rsp_if.source           o_rsp
);
    import fnpa_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // Next-link store. An entry is only trusted once written; before that its
    // value is the in-order link of its block. Only frees write it, and only
    // into grown blocks, so a freshly grown block always reads in order.
    // The link of the node just appended at the tail is not cleared: it is
    // never read before the next free overwrites it.
    t_idx                   r_link_mem [TOTAL_NODES];
    logic [TOTAL_NODES-1:0] r_link_vld;
    t_idx                   r_rd_data;
    logic                   r_rd_vld;

    // control state
    logic    r_state;
    t_lim    r_limit;
    t_idx    r_head,  n_head;
    t_idx    r_tail,  n_tail;
    logic    r_empty, n_empty;
    t_grown  r_grown, n_grown;
    t_cnt    r_free,  n_free;
    t_cnt    r_used,  n_used;

    // captured request beat
    logic    r_mode;
    t_idx    r_idx;

    // response register
    logic    r_out_valid;
    t_status r_status,  n_status;
    t_idx    r_granted, n_granted;
    t_cnt    r_free_o;
    t_cnt    r_used_o;

    logic    req_acc;
    logic    finish;
    logic    can_grow;
    t_idx    base;
    t_idx    base_last;
    t_idx    link_val;
    logic    wr_en;

    assign req_acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // a result is retired once the response register is free or draining
    assign finish = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    // block limit: 0 acts as 1, anything above MAX_BLOCKS saturates
    assign can_grow = int'(r_grown) <
                      ((r_limit == '0) ? 1 :
                       ((int'(r_limit) > MAX_BLOCKS) ? MAX_BLOCKS : int'(r_limit)));

    assign base      = block_base(r_grown);
    assign base_last = block_last(r_grown);
    assign link_val  = r_rd_vld ? r_rd_data : implicit_link(r_head);

    // append at the tail of a non-empty list
    assign wr_en = finish && (r_mode == MODE_FREE) && (n_status == ST_OK) && !r_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_link_mem[r_tail] <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_rd_data <= r_link_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= '0;
        end else if (wr_en) begin
            r_link_vld[r_tail] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_rd_vld <= r_link_vld[r_head];
            r_mode   <= i_req.mode;
            r_idx    <= i_req.node_index;
        end
    end

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_empty   = r_empty;
        n_grown   = r_grown;
        n_free    = r_free;
        n_used    = r_used;
        n_status  = ST_OK;
        n_granted = '0;
        case (r_mode)
            MODE_ALLOC: begin
                if (r_empty) begin
                    if (can_grow) begin
                        // grow, then pop the first node of the new block
                        n_granted = base;
                        n_head    = t_idx'(base + t_idx'(1));
                        n_tail    = base_last;
                        n_empty   = 1'b0;
                        n_grown   = t_grown'(r_grown + t_grown'(1));
                        n_free    = t_cnt'(r_free + t_cnt'(NODES_PER_BLOCK - 1));
                        n_used    = t_cnt'(r_used + t_cnt'(1));
                    end else begin
                        n_status = ST_EXHAUSTED;
                    end
                end else begin
                    n_granted = r_head;
                    n_used    = t_cnt'(r_used + t_cnt'(1));
                    if (r_head == r_tail) begin
                        // last node gone: link a further block at once if allowed
                        if (can_grow) begin
                            n_head  = base;
                            n_tail  = base_last;
                            n_grown = t_grown'(r_grown + t_grown'(1));
                            n_free  = t_cnt'(r_free + t_cnt'(NODES_PER_BLOCK - 1));
                        end else begin
                            n_empty = 1'b1;
                            n_free  = t_cnt'(r_free - t_cnt'(1));
                        end
                    end else begin
                        n_head = link_val;
                        n_free = t_cnt'(r_free - t_cnt'(1));
                    end
                end
            end
            MODE_FREE: begin
                if ((r_used == '0) || ({1'b0, r_idx} >= grown_end(r_grown))) begin
                    n_status = ST_REJECTED;
                end else begin
                    if (r_empty) begin
                        n_head  = r_idx;
                        n_empty = 1'b0;
                    end
                    n_tail = r_idx;
                    n_free = t_cnt'(r_free + t_cnt'(1));
                    n_used = t_cnt'(r_used - t_cnt'(1));
                end
            end
            default: begin
                n_status = ST_REJECTED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= t_lim'(4);
            r_head      <= '0;
            r_tail      <= t_idx'(NODES_PER_BLOCK - 1);
            r_empty     <= 1'b0;
            r_grown     <= t_grown'(1);
            r_free      <= t_cnt'(NODES_PER_BLOCK);
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (finish) begin
                        r_state <= S_IDLE;
                        r_head  <= n_head;
                        r_tail  <= n_tail;
                        r_empty <= n_empty;
                        r_grown <= n_grown;
                        r_free  <= n_free;
                        r_used  <= n_used;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_status  <= n_status;
            r_granted <= n_granted;
            r_free_o  <= n_free;
            r_used_o  <= n_used;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.granted_index = r_granted;
    assign o_rsp.free_count    = r_free_o;
    assign o_rsp.used_count    = r_used_o;

    // every grown node is either free or handed out
    a_node_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_free) + int'(r_used)) == int'(r_grown) * NODES_PER_BLOCK)
        else $error("free and used counts do not cover the grown blocks");

    // a stalled response beat stays put until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=>
            (o_rsp.valid && $stable(o_rsp.status) && $stable(o_rsp.granted_index)))
        else $error("response beat changed while stalled");

    // an accepted beat always moves on to the update cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_EXEC))
        else $error("accepted beat not processed");

endmodule

// ----- tb/tb_fixed_node_pool_allocator.sv -----
module tb_fixed_node_pool_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import fnpa_pkg::*;

    // One response beat as the pool reports it.
    typedef struct packed {
        t_status status;
        t_idx    granted_index;
        t_cnt    free_count;
        t_cnt    used_count;
    } alloc_rsp_t;

    // A result typed into the directed table overrides the predicted one.
    typedef struct {
        bit         pinned;
        alloc_rsp_t rsp;
    } typed_rsp_t;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e  kind;
        logic       mode;
        t_idx       idx;
        t_lim       limit;
        int         reps;
        bit         pinned;
        alloc_rsp_t rsp;
    } stim_row_t;

    // Receiver stall styles.
    typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_style_e;

    localparam alloc_rsp_t UNPINNED = '{ST_OK, 6'd0, 7'd0, 7'd0};
    localparam int         N_DIR    = 25;
    localparam int         N_PHASE  = 6;
    localparam int         PHASE_LEN = 195;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_lim i_cfg_wdata;

    fnpa_req_if req_if();
    fnpa_rsp_if rsp_if();

    fixed_node_pool_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // ------------------------------------------------------------------
    // Pool predictor: free list as next-pointer store, FIFO order.
    // ------------------------------------------------------------------
    t_lim pool_limit;
    t_idx pool_link [TOTAL_NODES];
    t_idx pool_head;
    t_idx pool_tail;
    bit   pool_empty;
    int   pool_grown;
    int   pool_free;
    int   pool_used;
    t_idx held_q[$];            // nodes the pool has handed out, by prediction

    alloc_rsp_t pending_rsp_q[$];
    typed_rsp_t typed_rsp_q[$];
    int         mismatch_cnt;
    int         rsp_count;

    // Sender bookkeeping
    bit req_up;
    int burst_left;

    function automatic int usable_blocks();
        int l;
        l = int'(pool_limit);
        if (l < 1) l = 1;
        if (l > MAX_BLOCKS) l = MAX_BLOCKS;
        return l;
    endfunction

    // Link block b in order and make it the whole free list.
    function automatic void link_block(int b);
        int base;
        base = b * NODES_PER_BLOCK;
        for (int i = 0; i < NODES_PER_BLOCK - 1; i++) begin
            pool_link[base + i] = t_idx'(base + i + 1);
        end
        pool_link[base + NODES_PER_BLOCK - 1] = '0;
        pool_head  = t_idx'(base);
        pool_tail  = t_idx'(base + NODES_PER_BLOCK - 1);
        pool_empty = 1'b0;
        pool_free += NODES_PER_BLOCK;
    endfunction

    function automatic bit grow_block();
        if (pool_grown >= usable_blocks()) return 1'b0;
        link_block(pool_grown);
        pool_grown++;
        return 1'b1;
    endfunction

    function automatic void pool_reset();
        foreach (pool_link[i]) pool_link[i] = '0;
        pool_limit = 3'd4;
        pool_grown = 1;
        pool_free  = 0;
        pool_used  = 0;
        held_q.delete();
        link_block(0);
    endfunction

    function automatic alloc_rsp_t pool_step(logic m, t_idx idx);
        alloc_rsp_t r;
        r = UNPINNED;
        if (m == MODE_ALLOC) begin
            // empty list: try to grow first, the limit may have gone up
            if (pool_empty && !grow_block()) begin
                r.status = ST_EXHAUSTED;
            end else begin
                r.granted_index = pool_head;
                if (pool_head == pool_tail) begin
                    pool_empty = 1'b1;
                end else begin
                    pool_head = pool_link[pool_head];
                end
                pool_free--;
                pool_used++;
                held_q.push_back(r.granted_index);
                // last node went out: link the next block right away if allowed
                if (pool_empty) void'(grow_block());
            end
        end else begin
            // nothing out, or index beyond the grown blocks: rejected
            if (pool_used == 0 || int'(idx) >= pool_grown * NODES_PER_BLOCK) begin
                r.status = ST_REJECTED;
            end else begin
                if (pool_empty) begin
                    pool_head  = idx;
                    pool_empty = 1'b0;
                end else begin
                    pool_link[pool_tail] = idx;
                end
                pool_tail      = idx;
                pool_link[idx] = '0;
                pool_free++;
                pool_used--;
                for (int k = 0; k < held_q.size(); k++) begin
                    if (held_q[k] == idx) begin
                        held_q.delete(k);
                        break;
                    end
                end
            end
        end
        r.free_count = t_cnt'(pool_free);
        r.used_count = t_cnt'(pool_used);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Typed results only where obvious; rest predicted.
    // ------------------------------------------------------------------
    stim_row_t dir_tbl [N_DIR] = '{
        // free with nothing out
        '{ROW_BEAT, MODE_FREE,  6'd0,  3'd0, 1,  1'b1, '{ST_REJECTED,  6'd0,  7'd16, 7'd0}},
        '{ROW_BEAT, MODE_ALLOC, 6'd0,  3'd0, 1,  1'b1, '{ST_OK,        6'd0,  7'd15, 7'd1}},
        // indices outside the grown block
        '{ROW_BEAT, MODE_FREE,  6'd63, 3'd0, 1,  1'b1, '{ST_REJECTED,  6'd0,  7'd15, 7'd1}},
        '{ROW_BEAT, MODE_FREE,  6'd16, 3'd0, 1,  1'b1, '{ST_REJECTED,  6'd0,  7'd15, 7'd1}},
        '{ROW_BEAT, MODE_FREE,  6'd0,  3'd0, 1,  1'b1, '{ST_OK,        6'd0,  7'd16, 7'd0}},
        // one block only: drain it
        '{ROW_CFG,  MODE_ALLOC, 6'd0,  3'd1, 1,  1'b0, UNPINNED},
        '{ROW_BEAT, MODE_ALLOC, 6'd63, 3'd0, 15, 1'b0, UNPINNED},
        '{ROW_BEAT, MODE_ALLOC, 6'd0,  3'd0, 1,  1'b1, '{ST_OK,        6'd0,  7'd0,  7'd16}},
        '{ROW_BEAT, MODE_ALLOC, 6'd0,  3'd0, 1,  1'b1, '{ST_EXHAUSTED, 6'd0,  7'd0,  7'd16}},
        '{ROW_BEAT, MODE_FREE,  6'd63, 3'd0, 1,  1'b1, '{ST_REJECTED,  6'd0,  7'd0,  7'd16}},
        // free onto an empty list, then take it back
        '{ROW_BEAT, MODE_FREE,  6'd5,  3'd0, 1,  1'b1, '{ST_OK,        6'd0,  7'd1,  7'd15}},
        '{ROW_BEAT, MODE_ALLOC, 6'd0,  3'd0, 1,  1'b1, '{ST_OK,        6'd5,  7'd0,  7'd16}},
        // limit 0 behaves as 1
        '{ROW_CFG,  MODE_ALLOC, 6'd0,  3'd0, 1,  1'b0, UNPINNED},
        '{ROW_BEAT, MODE_ALLOC, 6'd0,  3'd0, 1,  1'b1, '{ST_EXHAUSTED, 6'd0,  7'd0,  7'd16}},
        // limit 7 behaves as MAX_BLOCKS: grow on an empty list
        '{ROW_CFG,  MODE_ALLOC, 6'd0,  3'd7, 1,  1'b0, UNPINNED},
        '{ROW_BEAT, MODE_ALLOC, 6'd0,  3'd0, 1,  1'b1, '{ST_OK,        6'd16, 7'd15, 7'd17}},
        '{ROW_BEAT, MODE_ALLOC, 6'd0,  3'd0, 14, 1'b0, UNPINNED},
        // last node of block 1 granted, block 2 linked at once
        '{ROW_BEAT, MODE_ALLOC, 6'd0,  3'd0, 1,  1'b1, '{ST_OK,        6'd31, 7'd16, 7'd32}},
        '{ROW_BEAT, MODE_ALLOC, 6'd0,  3'd0, 16, 1'b0, UNPINNED},
        '{ROW_BEAT, MODE_ALLOC, 6'd0,  3'd0, 15, 1'b0, UNPINNED},
        // whole pool out
        '{ROW_BEAT, MODE_ALLOC, 6'd0,  3'd0, 1,  1'b1, '{ST_OK,        6'd63, 7'd0,  7'd64}},
        '{ROW_BEAT, MODE_ALLOC, 6'd0,  3'd0, 1,  1'b1, '{ST_EXHAUSTED, 6'd0,  7'd0,  7'd64}},
        '{ROW_BEAT, MODE_FREE,  6'd63, 3'd0, 1,  1'b1, '{ST_OK,        6'd0,  7'd1,  7'd63}},
        // double free, not detected
        '{ROW_BEAT, MODE_FREE,  6'd63, 3'd0, 1,  1'b0, UNPINNED},
        '{ROW_CFG,  MODE_ALLOC, 6'd0,  3'd4, 1,  1'b0, UNPINNED}
    };

    // Random phases: block limit and share of allocate requests (percent).
    t_lim phase_limit [N_PHASE] = '{3'd2, 3'd0, 3'd7, 3'd3, 3'd5, 3'd1};
    int   phase_alloc [N_PHASE] = '{80, 35, 65, 25, 70, 50};

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_fixed_node_pool_allocator: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    task automatic drop_valid();
        if (req_up) begin
            req_if.valid <= 1'b0;
            req_up = 1'b0;
        end
    endtask

    // Count down the burst; at its end idle a while, then pick the next burst length.
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            drop_valid();
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(12, 30)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic offer_beat(input logic m, input t_idx idx, input bit pin,
                              input alloc_rsp_t want);
        typed_rsp_t t;
        t.pinned = pin;
        t.rsp    = want;
        typed_rsp_q.push_back(t);
        req_if.valid      <= 1'b1;
        req_if.mode       <= m;
        req_if.node_index <= idx;
        req_up = 1'b1;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pace();
    endtask

    // Register write only with the pool idle.
    task automatic write_limit(input t_lim v);
        drop_valid();
        // offered beats stay in typed_rsp_q until accepted, then in pending_rsp_q
        while (typed_rsp_q.size() + pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        pool_limit = v;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        logic m;
        t_idx idx;

        mismatch_cnt = 0;
        rsp_count    = 0;
        req_up       = 1'b0;
        burst_left   = 0;
        pool_reset();

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        req_if.valid      <= 1'b0;
        req_if.mode       <= MODE_ALLOC;
        req_if.node_index <= '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tbl[r]) begin
            if (dir_tbl[r].kind == ROW_CFG) begin
                write_limit(dir_tbl[r].limit);
            end else begin
                repeat (dir_tbl[r].reps) begin
                    offer_beat(dir_tbl[r].mode, dir_tbl[r].idx, dir_tbl[r].pinned,
                               dir_tbl[r].rsp);
                end
            end
        end

        // Random part: allocates and frees by phase share; frees mostly of nodes really out, some stray indices.
        for (int p = 0; p < N_PHASE; p++) begin
            write_limit(phase_limit[p]);
            repeat (PHASE_LEN) begin
                if ($urandom_range(0, 99) < phase_alloc[p]) begin
                    m   = MODE_ALLOC;
                    idx = t_idx'($urandom_range(0, 63));
                end else begin
                    m = MODE_FREE;
                    if (held_q.size() > 0 && $urandom_range(0, 99) < 85) begin
                        idx = held_q[$urandom_range(0, held_q.size() - 1)];
                    end else begin
                        idx = t_idx'($urandom_range(0, 63));
                    end
                end
                offer_beat(m, idx, 1'b0, UNPINNED);
            end
        end

        drop_valid();
        while (typed_rsp_q.size() + pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("tb_fixed_node_pool_allocator: done, clean");
        end else begin
            $display("tb_fixed_node_pool_allocator: done, errors");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: stall styles that change at random, plus two long
    // hold-offs so the pool backs up and drops its request ready.
    // ------------------------------------------------------------------
    initial begin : rx_pace
        rx_style_e style;
        int        style_left;
        int        hold_left;
        int        tick;
        bit        hold_a;
        bit        hold_b;

        style      = RX_OPEN;
        style_left = 0;
        hold_left  = 0;
        tick       = 0;
        hold_a     = 1'b0;
        hold_b     = 1'b0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (!hold_a && rsp_count >= 300) begin
                hold_a    = 1'b1;
                hold_left = 90;
            end
            if (!hold_b && rsp_count >= 900) begin
                hold_b    = 1'b1;
                hold_left = 60;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                if (style_left == 0) begin
                    style      = rx_style_e'($urandom_range(0, 3));
                    style_left = $urandom_range(10, 80);
                end
                style_left--;
                case (style)
                    RX_OPEN:  rsp_if.ready <= 1'b1;
                    RX_LIGHT: rsp_if.ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY: rsp_if.ready <= ($urandom_range(0, 2) == 0);
                    default:  rsp_if.ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check response beats, predict accepted request beats.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : beat_mon
        alloc_rsp_t want;
        alloc_rsp_t got;
        typed_rsp_t t;

        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                rsp_count++;
                got = '{rsp_if.status, rsp_if.granted_index,
                        rsp_if.free_count, rsp_if.used_count};
                if (pending_rsp_q.size() == 0) begin
                    $display("%0t: response beat with nothing pending, got %h", $time, got);
                    mismatch_cnt++;
                end else begin
                    want = pending_rsp_q.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                        mismatch_cnt++;
                    end
                    if (got.granted_index !== want.granted_index) begin
                        $display("%0t: granted_index expected %0d got %0d",
                                 $time, want.granted_index, got.granted_index);
                        mismatch_cnt++;
                    end
                    if (got.free_count !== want.free_count) begin
                        $display("%0t: free_count expected %0d got %0d",
                                 $time, want.free_count, got.free_count);
                        mismatch_cnt++;
                    end
                    if (got.used_count !== want.used_count) begin
                        $display("%0t: used_count expected %0d got %0d",
                                 $time, want.used_count, got.used_count);
                        mismatch_cnt++;
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                t    = typed_rsp_q.pop_front();
                want = pool_step(req_if.mode, req_if.node_index);
                pending_rsp_q.push_back(t.pinned ? t.rsp : want);
            end
        end
    end

endmodule
